### hw/rtl/ut2cal_pkg.sv
// Constants and helpers shared by the seconds-to-calendar conversion pipeline.
`timescale 1ns / 1ps

package ut2cal_pkg;

  // Output field widths
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int MDAY_W  = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // Reciprocal division: q = (x * RECIP) >> SHIFT, RECIP = ceil(2^SHIFT / d).
  // SHIFT >= width(x) + clog2(d) makes the quotient exact for every x.

  // seconds / 86400 done as (seconds >> 7) / 675, x is 25 bits
  localparam int             DAY_SHIFT = 35;
  localparam logic [25:0]    DAY_RECIP =
    26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);

  // (4r + 3) / 146097, x is 24 bits
  localparam int             CENT_SHIFT = 42;
  localparam logic [24:0]    CENT_RECIP =
    25'(((64'd1 << CENT_SHIFT) + 64'd146096) / 64'd146097);

  // time of day / 3600, x is 17 bits
  localparam int             HOUR_SHIFT = 29;
  localparam logic [17:0]    HOUR_RECIP =
    18'(((64'd1 << HOUR_SHIFT) + 64'd3599) / 64'd3600);

  // (days + 3) / 7, x is 17 bits
  localparam int             WDAY_SHIFT = 20;
  localparam logic [17:0]    WDAY_RECIP =
    18'(((64'd1 << WDAY_SHIFT) + 64'd6) / 64'd7);

  // (4r + 3) / 1461, x is 18 bits
  localparam int             YR_SHIFT = 29;
  localparam logic [18:0]    YR_RECIP =
    19'(((64'd1 << YR_SHIFT) + 64'd1460) / 64'd1461);

  // seconds within the hour / 60, x is 12 bits
  localparam int             MIN_SHIFT = 18;
  localparam logic [12:0]    MIN_RECIP =
    13'(((64'd1 << MIN_SHIFT) + 64'd59) / 64'd60);

  // (5r + 2) / 153, x is 11 bits
  localparam int             MO_SHIFT = 19;
  localparam logic [11:0]    MO_RECIP =
    12'(((64'd1 << MO_SHIFT) + 64'd152) / 64'd153);

  // Calendar constants
  localparam logic [21:0] FVF_DAY_OFFSET = 22'd2472632;  // 2440588 + 32044
  localparam logic [16:0] EPOCH_WDAY     = 17'd3;        // 1970-01-01 is a Thursday
  localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN   = 12'd60;
  localparam logic [23:0] DAYS_PER_400Y  = 24'd146097;
  localparam logic [17:0] DAYS_PER_4Y    = 18'd1461;
  localparam logic [16:0] DAYS_PER_WEEK  = 17'd7;
  localparam logic [13:0] YEARS_PER_CENT = 14'd100;
  localparam logic [13:0] YEAR_BASE      = 14'd4800;
  localparam logic [3:0]  MONTH_WRAP     = 4'd10;   // March-based index of January

  // (153 * mo + 2) / 5 for the March-based month index
  function automatic logic [8:0] month_start(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

### hw/rtl/unix_time_to_calendar_core.sv
// Pipelined conversion of 32-bit epoch seconds to calendar date, time and weekday.
`timescale 1ns / 1ps

// Usage
//   Input: drive seconds_since_epoch and pulse start. An item is taken at any
//   edge where start is high and busy is low. busy stays low, so one item can
//   be taken in every cycle.
//   Output: done is high for exactly one cycle per item, with year, month,
//   day_of_month, hour, minute, second and weekday (0 = Monday) valid in
//   that same cycle. Results leave in the order the items came in.
//   Each item passes register stages 1 to 7 and then the output register.
//   Throughput: one item per cycle.
//   The pipeline has eight register stages; they hold the constant-
//   reciprocal multipliers (divide by 86400, 146097, 1461, 153, 3600, 60, 7)
//   and the multiply-subtracts that form the remainders after them.
//   Reset (rst, synchronous) clears all stage valid bits; items in flight
//   are dropped and done stays low until new items arrive.
//   The receiver cannot hold results off, so nothing backs up into the
//   pipeline and no stage ever waits.
module unix_time_to_calendar_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [31:0]                  seconds_since_epoch,
  output logic                         done,
  output logic [ut2cal_pkg::YEAR_W-1:0]  year,
  output logic [ut2cal_pkg::MONTH_W-1:0] month,
  output logic [ut2cal_pkg::MDAY_W-1:0]  day_of_month,
  output logic [ut2cal_pkg::HOUR_W-1:0]  hour,
  output logic [ut2cal_pkg::MIN_W-1:0]   minute,
  output logic [ut2cal_pkg::SEC_W-1:0]   second,
  output logic [ut2cal_pkg::WDAY_W-1:0]  weekday
);
  import ut2cal_pkg::*;

  // stage valid bits
  logic [7:1] vld;

  // stage 1
  logic [50:0] day_prod_s1;
  logic [16:0] t_s1;
  // stage 2
  logic [15:0] days_s2;
  logic [16:0] tod_s2;
  // stage 3
  logic [21:0] r_s3;
  logic [48:0] cent_prod_s3;
  logic [16:0] tod_s3;
  logic [34:0] hour_prod_s3;
  logic [16:0] wk_n_s3;
  logic [34:0] wk_prod_s3;
  // stage 4
  logic [6:0]  cent_s4;
  logic [15:0] r2_s4;
  logic [4:0]  hour_s4;
  logic [11:0] remh_s4;
  logic [2:0]  wday_s4;
  // stage 5
  logic [6:0]  cent_s5;
  logic [15:0] r2_s5;
  logic [36:0] yr_prod_s5;
  logic [4:0]  hour_s5;
  logic [11:0] remh_s5;
  logic [24:0] min_prod_s5;
  logic [2:0]  wday_s5;
  // stage 6
  logic [6:0]  cent_s6;
  logic [6:0]  yr_s6;
  logic [8:0]  r3_s6;
  logic [4:0]  hour_s6;
  logic [5:0]  min_s6;
  logic [5:0]  sec_s6;
  logic [2:0]  wday_s6;
  // stage 7
  logic [6:0]  cent_s7;
  logic [6:0]  yr_s7;
  logic [8:0]  r3_s7;
  logic [22:0] mo_prod_s7;
  logic [4:0]  hour_s7;
  logic [5:0]  min_s7;
  logic [5:0]  sec_s7;
  logic [2:0]  wday_s7;

  // combinational per stage
  logic [50:0] day_prod;
  logic [15:0] days;
  logic [31:0] day_secs;
  logic [16:0] tod;
  logic [21:0] r_cent;
  logic [23:0] n_cent;
  logic [48:0] cent_prod;
  logic [34:0] hour_prod;
  logic [16:0] wk_n;
  logic [34:0] wk_prod;
  logic [6:0]  cent;
  logic [23:0] cent_days;
  logic [21:0] r2_full;
  logic [4:0]  hour_q;
  logic [16:0] hour_secs;
  logic [16:0] remh_full;
  logic [14:0] wk_q;
  logic [16:0] wk_rem;
  logic [17:0] n_yr;
  logic [36:0] yr_prod;
  logic [24:0] min_prod;
  logic [6:0]  yr;
  logic [17:0] yr_days;
  logic [15:0] r3_full;
  logic [5:0]  min_q;
  logic [11:0] sec_full;
  logic [10:0] n_mo;
  logic [22:0] mo_prod;
  logic [3:0]  mo;
  logic        corr;
  logic [8:0]  mday_full;
  logic [3:0]  month_next;
  logic [13:0] year_full;

  // results are never held back, so input is always open
  assign busy = 1'b0;

  always_comb begin
    // stage 0: day count
    day_prod   = 51'(seconds_since_epoch[31:7]) * 51'(DAY_RECIP);
    // stage 1: time of day
    days       = day_prod_s1[50:35];
    day_secs   = 32'(days) * 32'(SECS_PER_DAY);
    tod        = t_s1 - day_secs[16:0];
    // stage 2: century quotient, hour quotient, weekday quotient
    r_cent     = {6'd0, days_s2} + FVF_DAY_OFFSET;
    n_cent     = {r_cent, 2'b11};
    cent_prod  = 49'(n_cent) * 49'(CENT_RECIP);
    hour_prod  = 35'(tod_s2) * 35'(HOUR_RECIP);
    wk_n       = {1'b0, days_s2} + EPOCH_WDAY;
    wk_prod    = 35'(wk_n) * 35'(WDAY_RECIP);
    // stage 3: remainders
    cent       = cent_prod_s3[48:42];
    cent_days  = 24'(cent) * DAYS_PER_400Y;
    r2_full    = r_s3 - cent_days[23:2];
    hour_q     = hour_prod_s3[33:29];
    hour_secs  = 17'(hour_q) * SECS_PER_HOUR;
    remh_full  = tod_s3 - hour_secs;
    wk_q       = wk_prod_s3[34:20];
    wk_rem     = wk_n_s3 - 17'(wk_q) * DAYS_PER_WEEK;
    // stage 4: year-in-century quotient, minute quotient
    n_yr       = {r2_s4, 2'b11};
    yr_prod    = 37'(n_yr) * 37'(YR_RECIP);
    min_prod   = 25'(remh_s4) * 25'(MIN_RECIP);
    // stage 5: day of year, second
    yr         = yr_prod_s5[35:29];
    yr_days    = 18'(yr) * DAYS_PER_4Y;
    r3_full    = r2_s5 - yr_days[17:2];
    min_q      = min_prod_s5[23:18];
    sec_full   = remh_s5 - 12'(min_q) * SECS_PER_MIN;
    // stage 6: March-based month quotient
    n_mo       = 11'(11'(r3_s6) * 11'd5 + 11'd2);
    mo_prod    = 23'(n_mo) * 23'(MO_RECIP);
    // stage 7: final date fields
    mo         = mo_prod_s7[22:19];
    corr       = (mo >= MONTH_WRAP);
    mday_full  = r3_s7 - month_start(mo) + 9'd1;
    month_next = corr ? (mo - 4'd9) : (mo + 4'd3);
    year_full  = 14'(cent_s7) * YEARS_PER_CENT + 14'(yr_s7) + 14'(corr) - YEAR_BASE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[6:1], start & ~busy};
      done <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    // stage 1
    day_prod_s1  <= day_prod;
    t_s1         <= seconds_since_epoch[16:0];
    // stage 2
    days_s2      <= days;
    tod_s2       <= tod;
    // stage 3
    r_s3         <= r_cent;
    cent_prod_s3 <= cent_prod;
    tod_s3       <= tod_s2;
    hour_prod_s3 <= hour_prod;
    wk_n_s3      <= wk_n;
    wk_prod_s3   <= wk_prod;
    // stage 4
    cent_s4      <= cent;
    r2_s4        <= r2_full[15:0];
    hour_s4      <= hour_q;
    remh_s4      <= remh_full[11:0];
    wday_s4      <= wk_rem[2:0];
    // stage 5
    cent_s5      <= cent_s4;
    r2_s5        <= r2_s4;
    yr_prod_s5   <= yr_prod;
    hour_s5      <= hour_s4;
    remh_s5      <= remh_s4;
    min_prod_s5  <= min_prod;
    wday_s5      <= wday_s4;
    // stage 6
    cent_s6      <= cent_s5;
    yr_s6        <= yr;
    r3_s6        <= r3_full[8:0];
    hour_s6      <= hour_s5;
    min_s6       <= min_q;
    sec_s6       <= sec_full[5:0];
    wday_s6      <= wday_s5;
    // stage 7
    cent_s7      <= cent_s6;
    yr_s7        <= yr_s6;
    r3_s7        <= r3_s6;
    mo_prod_s7   <= mo_prod;
    hour_s7      <= hour_s6;
    min_s7       <= min_s6;
    sec_s7       <= sec_s6;
    wday_s7      <= wday_s6;
    // output
    year         <= year_full[YEAR_W-1:0];
    month        <= month_next;
    day_of_month <= mday_full[MDAY_W-1:0];
    hour         <= hour_s7;
    minute       <= min_s7;
    second       <= sec_s7;
    weekday      <= wday_s7;
  end

endmodule

### bench/unix_time_to_calendar_core_tb.sv
// Self-checking testbench for the epoch-seconds to calendar conversion core.
`timescale 1ns / 1ps

module unix_time_to_calendar_core_tb;
  import ut2cal_pkg::*;

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [MDAY_W-1:0]  mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  weekday;
  } calendar_t;

  class calendar_scoreboard;
    calendar_t expected_dates[$];
    int        mismatches;
    int        checked;

    function new();
      mismatches = 0;
      checked    = 0;
    endfunction

    // Day count -> Julian day number -> Fliegel-Van Flandern split.
    function calendar_t to_calendar(logic [31:0] secs);
      longint unsigned days, tod, jdn, r, cent, yr, mo, corr;
      calendar_t c;
      days = secs / 86400;
      tod  = secs % 86400;
      jdn  = days + 2440588;
      r    = jdn + 32044;
      cent = (4 * r + 3) / 146097;
      r    = r - (146097 * cent) / 4;
      yr   = (4 * r + 3) / 1461;
      r    = r - (1461 * yr) / 4;
      mo   = (5 * r + 2) / 153;
      corr = mo / 10;
      c.year    = YEAR_W'(100 * cent + yr + corr - 4800);
      c.month   = MONTH_W'(mo + 3 - 12 * corr);
      c.mday    = MDAY_W'(r - (153 * mo + 2) / 5 + 1);
      c.hour    = HOUR_W'(tod / 3600);
      c.minute  = MIN_W'((tod % 3600) / 60);
      c.second  = SEC_W'(tod % 60);
      c.weekday = WDAY_W'(jdn % 7);
      return c;
    endfunction

    function void note_timestamp(logic [31:0] secs);
      expected_dates.push_back(to_calendar(secs));
    endfunction

    function void report(string what, calendar_t exp_c, calendar_t got_c);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s exp %0d-%0d-%0d %0d:%0d:%0d wd%0d got %0d-%0d-%0d %0d:%0d:%0d wd%0d",
                 $realtime, what, exp_c.year, exp_c.month, exp_c.mday, exp_c.hour,
                 exp_c.minute, exp_c.second, exp_c.weekday, got_c.year, got_c.month,
                 got_c.mday, got_c.hour, got_c.minute, got_c.second, got_c.weekday);
    endfunction

    function void check_result(calendar_t got_c);
      calendar_t exp_c;
      if (expected_dates.size() == 0) begin
        report("unexpected result", '0, got_c);
        return;
      end
      exp_c = expected_dates.pop_front();
      checked++;
      if (got_c.year !== exp_c.year || got_c.month !== exp_c.month ||
          got_c.mday !== exp_c.mday || got_c.hour !== exp_c.hour ||
          got_c.minute !== exp_c.minute || got_c.second !== exp_c.second ||
          got_c.weekday !== exp_c.weekday)
        report("mismatch", exp_c, got_c);
    endfunction

    function int pending();
      return expected_dates.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [31:0] seconds_since_epoch;
  logic done;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [MDAY_W-1:0]  day_of_month;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SEC_W-1:0]   second;
  logic [WDAY_W-1:0]  weekday;

  calendar_scoreboard sb = new();
  int sent;

  unix_time_to_calendar_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .seconds_since_epoch(seconds_since_epoch),
    .done(done),
    .year(year),
    .month(month),
    .day_of_month(day_of_month),
    .hour(hour),
    .minute(minute),
    .second(second),
    .weekday(weekday)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Pre-edge values are sampled here, so drive order within the step does not matter.
  always @(posedge clk) begin : monitor
    calendar_t got_c;
    if (!rst) begin
      if (start && !busy) sb.note_timestamp(seconds_since_epoch);
      if (done) begin
        got_c.year    = year;
        got_c.month   = month;
        got_c.mday    = day_of_month;
        got_c.hour    = hour;
        got_c.minute  = minute;
        got_c.second  = second;
        got_c.weekday = weekday;
        sb.check_result(got_c);
      end
    end
  end

  // Called right after a rising edge; returns right after the accepting edge.
  // start is left high so a back-to-back item never toggles it.
  task automatic send_item(input logic [31:0] secs);
    start <= 1'b1;
    seconds_since_epoch <= secs;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    seconds_since_epoch <= $urandom;
    repeat (n) @(posedge clk);
  endtask

  // Half the timestamps near midnight, where the date rolls over; the other half full range.
  function automatic logic [31:0] random_timestamp();
    logic [31:0] day_start;
    day_start = $urandom_range(49709) * 86400;
    case ($urandom_range(3))
      0:       return day_start + $urandom_range(3);
      1:       return day_start + 86399 - $urandom_range(3);
      default: return $urandom;
    endcase
  endfunction

  logic [31:0] directed_ts[] = '{
    32'd0, 32'd1, 32'd86399, 32'd86400, 32'd31535999, 32'd31536000,
    32'd68169600,                    // 1972-02-29, first leap day
    32'd946684799, 32'd946684800,    // century turn
    32'd951782400, 32'd951868800,    // 2000-02-29 (400-year leap), 2000-03-01
    32'd4107542399, 32'd4107542400,  // 2100 is not a leap year
    32'd2147483647, 32'd2147483648,
    32'h5555_5555, 32'hAAAA_AAAA,
    32'd4294944000, 32'd4294967294, 32'd4294967295  // top of the input range
  };

  int idle_pct[3] = '{0, 76, 18};

  initial begin
    int wait_cycles;
    rst = 1'b1;
    start = 1'b0;
    seconds_since_epoch = '0;
    sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ts[i]) send_item(directed_ts[i]);

    // The receiver cannot stall, so pacing phases only vary the sender.
    foreach (idle_pct[p]) begin
      for (int i = 0; i < 500; i++) begin
        if (idle_pct[p] != 0 && $urandom_range(99) < idle_pct[p])
          idle_cycles($urandom_range(1, 4));
        send_item(random_timestamp());
      end
      idle_cycles($urandom_range(1, 10));
    end
    idle_cycles(1);

    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 100) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (16) @(posedge clk);

    if (sb.pending() != 0)
      $display("%0d expected results never arrived", sb.pending());
    $display("Converted %0d timestamps (%0d directed edge dates, rest random) over",
             sent, directed_ts.size());
    $display("three sender pacing phases; %0d results checked, %0d mismatches.",
             sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
